// File: sv/fcrp_pkg.sv
// Shared constants and types for the framed CSV record parser.
`timescale 1ns / 1ps
`default_nettype none

package fcrp_pkg;

   // Hex digits taken from the step field at most.
   localparam int STEP_DIGITS = 8;
   localparam int STEP_LEN_W  = $clog2(STEP_DIGITS + 1);

   // Field widths of the request and the response.
   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int STEP_W   = 32;

   // Framing and field characters.
   localparam logic [BYTE_W-1:0] START_BYTE = 8'h02;
   localparam logic [BYTE_W-1:0] END_BYTE   = 8'h03;
   localparam logic [BYTE_W-1:0] SEP_BYTE   = 8'h2C;
   localparam logic [BYTE_W-1:0] ACK_BYTE   = 8'h38;

   // Field numbers inside a frame.
   localparam logic [2:0] FIELD_ID   = 3'd1;
   localparam logic [2:0] FIELD_STEP = 3'd2;
   localparam logic [2:0] FIELD_POS  = 3'd3;
   localparam logic [2:0] FIELD_FLAG = 3'd4;
   localparam logic [2:0] FIELD_MAX  = 3'd7;

   // Record status codes.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACK   = 2'd0,
      STATUS_NACK  = 2'd1,
      STATUS_SHORT = 2'd2
   } status_type;

endpackage

`default_nettype wire

// File: sv/fcrp_req_if.sv
// Request channel carrying one received serial byte.
`timescale 1ns / 1ps
`default_nettype none

interface fcrp_req_if;
   logic                         valid;
   logic                         ready;
   logic [fcrp_pkg::BYTE_W-1:0]  rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// File: sv/fcrp_rsp_if.sv
// Response channel carrying one parsed record.
`timescale 1ns / 1ps
`default_nettype none

interface fcrp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [fcrp_pkg::STATUS_W-1:0] status;
   logic [fcrp_pkg::BYTE_W-1:0]   car_id;
   logic [fcrp_pkg::STEP_W-1:0]   step_value;
   logic [fcrp_pkg::BYTE_W-1:0]   position_char;

   modport source (output valid, output status, output car_id, output step_value,
                   output position_char, input ready);
   modport sink   (input valid, input status, input car_id, input step_value,
                   input position_char, output ready);
endinterface

`default_nettype wire

// File: sv/framed_csv_record_parser.sv
// Top level: STX/ETX framed CSV record parser.
// A record is registered as the byte that closes it leaves the input register.
// Throughput: one request per cycle; the input register advances whenever the
// byte it holds makes no record or the response register is free or being taken.
// Reset (synchronous, active high) leaves the block idle, waiting for a start
// byte, with empty input and response registers.
`timescale 1ns / 1ps
`default_nettype none

module framed_csv_record_parser (
   input  wire         clock,
   input  wire         reset,
   fcrp_req_if.sink    req_chan,
   fcrp_rsp_if.source  rsp_chan
);

   // Hex digit decode; bit 4 set means the byte is not a hex digit.
   function automatic logic [4:0] hex_value(input logic [fcrp_pkg::BYTE_W-1:0] c);
      logic [4:0] v;
      case (c) inside
         [8'h30:8'h39]: v = {1'b0, c[3:0]};
         [8'h41:8'h46],
         [8'h61:8'h66]: v = {1'b0, c[3:0] + 4'd9};
         default:       v = 5'h10;
      endcase
      return v;
   endfunction

   // Input register.
   logic                          in_vld_ff, in_vld_in;
   logic [fcrp_pkg::BYTE_W-1:0]   in_byte_ff;

   // Parser state.
   logic                          in_frame_ff, in_frame_in;
   logic [2:0]                    field_num_ff, field_num_in;
   logic [fcrp_pkg::BYTE_W-1:0]   id_accum_ff, id_accum_in;
   logic                          id_stopped_ff, id_stopped_in;
   logic [fcrp_pkg::STEP_W-1:0]   step_accum_ff, step_accum_in;
   logic                          step_stopped_ff, step_stopped_in;
   logic [fcrp_pkg::STEP_LEN_W-1:0] step_len_ff, step_len_in;
   logic [fcrp_pkg::BYTE_W-1:0]   pos_byte_ff, pos_byte_in;
   logic [fcrp_pkg::BYTE_W-1:0]   flag_byte_ff, flag_byte_in;
   logic                          flag_seen_ff, flag_seen_in;

   // Response register.
   logic                          rsp_vld_ff, rsp_vld_in;
   logic [fcrp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [fcrp_pkg::BYTE_W-1:0]   rsp_car_ff;
   logic [fcrp_pkg::STEP_W-1:0]   rsp_step_ff;
   logic [fcrp_pkg::BYTE_W-1:0]   rsp_pos_ff;

   // Handshake and control.
   logic                          is_end;
   logic                          out_free;
   logic                          fire;
   logic                          emit;
   logic                          req_take;
   logic [11:0]                   id_next;
   logic [4:0]                    hex_d;
   logic [fcrp_pkg::BYTE_W-1:0]   final_flag;
   logic                          final_seen;
   fcrp_pkg::status_type          status_next;

   // The held byte closes a frame; it may only advance if the response slot opens.
   assign is_end   = in_frame_ff && (in_byte_ff == fcrp_pkg::END_BYTE);
   assign out_free = !rsp_vld_ff || rsp_chan.ready;
   assign fire     = in_vld_ff && (!is_end || out_free);
   assign emit     = fire && is_end;
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready = !in_vld_ff || fire;
   assign in_vld_in      = req_take || (in_vld_ff && !fire);

   // Decimal id and hex step arithmetic on the held byte.
   assign id_next = ({4'd0, id_accum_ff} << 3) + ({4'd0, id_accum_ff} << 1)
                    + {8'd0, in_byte_ff[3:0]};
   assign hex_d   = hex_value(in_byte_ff);

   // Flag as it stands when the frame closes; an empty flag field takes the end byte.
   assign final_seen = flag_seen_ff;
   assign final_flag = flag_seen_ff ? flag_byte_ff : in_byte_ff;

   always_comb begin
      if (field_num_ff < fcrp_pkg::FIELD_FLAG) begin
         status_next = fcrp_pkg::STATUS_SHORT;
      end else if (final_flag == fcrp_pkg::ACK_BYTE) begin
         status_next = fcrp_pkg::STATUS_ACK;
      end else begin
         status_next = fcrp_pkg::STATUS_NACK;
      end
   end

   // Next parser state for the byte in the input register.
   always_comb begin
      in_frame_in     = in_frame_ff;
      field_num_in    = field_num_ff;
      id_accum_in     = id_accum_ff;
      id_stopped_in   = id_stopped_ff;
      step_accum_in   = step_accum_ff;
      step_stopped_in = step_stopped_ff;
      step_len_in     = step_len_ff;
      pos_byte_in     = pos_byte_ff;
      flag_byte_in    = flag_byte_ff;
      flag_seen_in    = flag_seen_ff;
      if (fire) begin
         if (!in_frame_ff) begin
            // Wait for a start byte, which opens a fresh frame.
            if (in_byte_ff == fcrp_pkg::START_BYTE) begin
               in_frame_in     = 1'b1;
               field_num_in    = 3'd0;
               id_accum_in     = '0;
               id_stopped_in   = 1'b0;
               step_accum_in   = '0;
               step_stopped_in = 1'b0;
               step_len_in     = '0;
               pos_byte_in     = '0;
               flag_byte_in    = '0;
               flag_seen_in    = 1'b0;
            end
         end else if (is_end) begin
            in_frame_in  = 1'b0;
            flag_byte_in = final_flag;
            flag_seen_in = final_seen || (field_num_ff >= fcrp_pkg::FIELD_FLAG);
         end else if (in_byte_ff == fcrp_pkg::SEP_BYTE) begin
            if (field_num_ff < fcrp_pkg::FIELD_MAX) begin
               field_num_in = field_num_ff + 3'd1;
            end
         end else begin
            case (field_num_ff)
               fcrp_pkg::FIELD_ID: begin
                  if (!id_stopped_ff) begin
                     if (in_byte_ff inside {[8'h30:8'h39]}) begin
                        id_accum_in = (id_next > 12'd255) ? 8'hFF : id_next[7:0];
                     end else begin
                        id_stopped_in = 1'b1;
                     end
                  end
               end
               fcrp_pkg::FIELD_STEP: begin
                  if (!step_stopped_ff) begin
                     if (hex_d[4]) begin
                        step_stopped_in = 1'b1;
                     end else begin
                        // A value that would shift bits out saturates instead.
                        if (step_accum_ff[fcrp_pkg::STEP_W-1 -: 4] != 4'd0) begin
                           step_accum_in = '1;
                        end else begin
                           step_accum_in = {step_accum_ff[fcrp_pkg::STEP_W-5:0], hex_d[3:0]};
                        end
                        step_len_in = step_len_ff + 1'b1;
                        if (step_len_in >= fcrp_pkg::STEP_LEN_W'(fcrp_pkg::STEP_DIGITS)) begin
                           step_stopped_in = 1'b1;
                        end
                     end
                  end
               end
               fcrp_pkg::FIELD_POS: begin
                  pos_byte_in = in_byte_ff;
               end
               fcrp_pkg::FIELD_FLAG: begin
                  if (!flag_seen_ff) begin
                     flag_byte_in = in_byte_ff;
                     flag_seen_in = 1'b1;
                  end
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Response valid: set by a closing byte, cleared once taken.
   always_comb begin
      if (emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_vld_in = 1'b0;
      end else begin
         rsp_vld_in = rsp_vld_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff       <= 1'b0;
         rsp_vld_ff      <= 1'b0;
         in_frame_ff     <= 1'b0;
         field_num_ff    <= 3'd0;
         id_accum_ff     <= '0;
         id_stopped_ff   <= 1'b0;
         step_accum_ff   <= '0;
         step_stopped_ff <= 1'b0;
         step_len_ff     <= '0;
         pos_byte_ff     <= '0;
         flag_byte_ff    <= '0;
         flag_seen_ff    <= 1'b0;
      end else begin
         in_vld_ff       <= in_vld_in;
         rsp_vld_ff      <= rsp_vld_in;
         in_frame_ff     <= in_frame_in;
         field_num_ff    <= field_num_in;
         id_accum_ff     <= id_accum_in;
         id_stopped_ff   <= id_stopped_in;
         step_accum_ff   <= step_accum_in;
         step_stopped_ff <= step_stopped_in;
         step_len_ff     <= step_len_in;
         pos_byte_ff     <= pos_byte_in;
         flag_byte_ff    <= flag_byte_in;
         flag_seen_ff    <= flag_seen_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.rx_byte;
      end
      if (emit) begin
         rsp_status_ff <= status_next;
         rsp_car_ff    <= id_accum_ff;
         rsp_step_ff   <= step_accum_ff;
         rsp_pos_ff    <= pos_byte_ff;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.car_id        = rsp_car_ff;
   assign rsp_chan.step_value    = rsp_step_ff;
   assign rsp_chan.position_char = rsp_pos_ff;

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for the framed CSV record parser.
`timescale 1ns / 1ps

module tb;

   // One parsed record as it leaves the response channel.
   typedef struct packed {
      fcrp_pkg::status_type                 status;
      logic [fcrp_pkg::BYTE_W-1:0]          car_id;
      logic [fcrp_pkg::STEP_W-1:0]          step_value;
      logic [fcrp_pkg::BYTE_W-1:0]          position_char;
   } parsed_record_type;

   // Tracks the parser state from accepted bytes and checks records in order.
   class record_scoreboard;
      bit                            in_frame;
      logic [2:0]                    field_no;
      logic [fcrp_pkg::BYTE_W-1:0]   id_value;
      bit                            id_done;
      logic [fcrp_pkg::STEP_W-1:0]   step_acc;
      bit                            step_done;
      int unsigned                   step_digits;
      logic [fcrp_pkg::BYTE_W-1:0]   pos_char;
      logic [fcrp_pkg::BYTE_W-1:0]   flag_char;
      bit                            flag_taken;
      parsed_record_type             records_due[$];
      int unsigned                   mismatches;
      int unsigned                   bytes_taken;

      function new();
         in_frame    = 0;
         mismatches  = 0;
         bytes_taken = 0;
         clear_frame();
      endfunction

      function void clear_frame();
         field_no    = '0;
         id_value    = '0;
         id_done     = 0;
         step_acc    = '0;
         step_done   = 0;
         step_digits = 0;
         pos_char    = '0;
         flag_char   = '0;
         flag_taken  = 0;
      endfunction

      // Advances the parser state by one accepted byte; an end byte inside a
      // frame queues the record it closes.
      function void note_byte(logic [fcrp_pkg::BYTE_W-1:0] c);
         parsed_record_type rec;
         int unsigned       sum;
         int unsigned       digit;
         bytes_taken++;
         if (!in_frame) begin
            if (c == fcrp_pkg::START_BYTE) begin
               clear_frame();
               in_frame = 1;
            end
            return;
         end
         if (c == fcrp_pkg::END_BYTE) begin
            if (field_no < fcrp_pkg::FIELD_FLAG) begin
               rec.status = fcrp_pkg::STATUS_SHORT;
            end else begin
               // An empty flag field leaves the end byte as the flag.
               if (!flag_taken) flag_char = c;
               rec.status = (flag_char == fcrp_pkg::ACK_BYTE) ? fcrp_pkg::STATUS_ACK
                                                              : fcrp_pkg::STATUS_NACK;
            end
            rec.car_id        = id_value;
            rec.step_value    = step_acc;
            rec.position_char = pos_char;
            records_due.push_back(rec);
            in_frame = 0;
            return;
         end
         if (c == fcrp_pkg::SEP_BYTE) begin
            if (field_no < fcrp_pkg::FIELD_MAX) field_no++;
            return;
         end
         case (field_no)
            fcrp_pkg::FIELD_ID: begin
               if (!id_done) begin
                  if (c >= "0" && c <= "9") begin
                     sum      = id_value * 10 + (c - "0");
                     id_value = (sum > 255) ? 8'd255 : sum[7:0];
                  end else begin
                     id_done = 1;
                  end
               end
            end
            fcrp_pkg::FIELD_STEP: begin
               if (!step_done) begin
                  if (c >= "0" && c <= "9")      digit = c - "0";
                  else if (c >= "A" && c <= "F") digit = c - "A" + 10;
                  else if (c >= "a" && c <= "f") digit = c - "a" + 10;
                  else                           digit = 16;
                  if (digit == 16) begin
                     step_done = 1;
                  end else begin
                     if (step_acc > 32'h0FFF_FFFF) step_acc = '1;
                     else step_acc = {step_acc[fcrp_pkg::STEP_W-5:0], digit[3:0]};
                     step_digits++;
                     if (step_digits >= fcrp_pkg::STEP_DIGITS) step_done = 1;
                  end
               end
            end
            fcrp_pkg::FIELD_POS: pos_char = c;
            fcrp_pkg::FIELD_FLAG: begin
               if (!flag_taken) begin
                  flag_char  = c;
                  flag_taken = 1;
               end
            end
            default: ;
         endcase
      endfunction

      task report_mismatch(string line);
         $display("%0t: %s", $time, line);
         mismatches++;
      endtask

      // Compares one record from the block with the oldest one predicted.
      task check_record(parsed_record_type got);
         parsed_record_type want;
         if (records_due.size() == 0) begin
            report_mismatch($sformatf("record with none pending: status %0d id %0d",
                                      got.status, got.car_id));
            return;
         end
         want = records_due.pop_front();
         if (got.status !== want.status)
            report_mismatch($sformatf("status got %0d expected %0d",
                                      got.status, want.status));
         if (got.car_id !== want.car_id)
            report_mismatch($sformatf("car_id got %0d expected %0d",
                                      got.car_id, want.car_id));
         if (got.step_value !== want.step_value)
            report_mismatch($sformatf("step_value got %h expected %h",
                                      got.step_value, want.step_value));
         if (got.position_char !== want.position_char)
            report_mismatch($sformatf("position_char got %h expected %h",
                                      got.position_char, want.position_char));
      endtask
   endclass

   localparam int RANDOM_BYTES = 1450;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 300;

   logic clock;
   logic reset;

   fcrp_req_if req_if ();
   fcrp_rsp_if rsp_if ();

   framed_csv_record_parser dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   record_scoreboard               sb = new();
   logic [fcrp_pkg::BYTE_W-1:0]    serial_bytes[$];
   bit                             quiet_tail = 0;
   bit                             long_hold_done = 0;
   int unsigned                    idle_cycles = 0;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Any byte that neither ends a frame nor separates fields.
   function automatic logic [fcrp_pkg::BYTE_W-1:0] data_byte();
      logic [fcrp_pkg::BYTE_W-1:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b == fcrp_pkg::END_BYTE || b == fcrp_pkg::SEP_BYTE);
      return b;
   endfunction

   function automatic void push_text(string s);
      for (int i = 0; i < s.len(); i++) serial_bytes.push_back(s[i]);
   endfunction

   // A frame with random field contents; a few are short or carry extra fields.
   function automatic void push_random_frame();
      string hex_chars = "0123456789abcdefABCDEF";
      int    shape;
      int    commas;
      int    choice;
      shape  = $urandom_range(0, 9);
      commas = (shape == 0) ? $urandom_range(0, 3) :
               (shape == 1) ? $urandom_range(5, 9) : 4;
      serial_bytes.push_back(fcrp_pkg::START_BYTE);
      repeat ($urandom_range(0, 2)) serial_bytes.push_back(data_byte());
      for (int f = 1; f <= commas; f++) begin
         serial_bytes.push_back(fcrp_pkg::SEP_BYTE);
         case (f)
            fcrp_pkg::FIELD_ID: begin
               repeat ($urandom_range(0, 4))
                  serial_bytes.push_back(8'("0" + $urandom_range(0, 9)));
               if ($urandom_range(0, 3) == 0) begin
                  serial_bytes.push_back(data_byte());
                  repeat ($urandom_range(0, 2))
                     serial_bytes.push_back(8'("0" + $urandom_range(0, 9)));
               end
            end
            fcrp_pkg::FIELD_STEP: begin
               repeat ($urandom_range(0, 10))
                  serial_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
               if ($urandom_range(0, 4) == 0) begin
                  serial_bytes.push_back(($urandom_range(0, 1) == 0) ? "x" : data_byte());
                  repeat ($urandom_range(0, 3))
                     serial_bytes.push_back(hex_chars[$urandom_range(0, 21)]);
               end
            end
            fcrp_pkg::FIELD_POS:
               repeat ($urandom_range(0, 3)) serial_bytes.push_back(data_byte());
            fcrp_pkg::FIELD_FLAG: begin
               choice = $urandom_range(0, 19);
               if (choice < 12)      serial_bytes.push_back(fcrp_pkg::ACK_BYTE);
               else if (choice < 17) serial_bytes.push_back(data_byte());
               if ($urandom_range(0, 3) == 0)
                  repeat ($urandom_range(1, 2)) serial_bytes.push_back(data_byte());
            end
            default:
               repeat ($urandom_range(0, 2)) serial_bytes.push_back(data_byte());
         endcase
      end
      serial_bytes.push_back(fcrp_pkg::END_BYTE);
   endfunction

   function automatic void build_stimulus();
      int unsigned target;
      // A stray end byte while idle is dropped.
      serial_bytes.push_back(fcrp_pkg::END_BYTE);
      // A start byte inside a frame is data; the id saturates; a 0x prefix
      // stops the step digits; too few fields.
      serial_bytes.push_back(fcrp_pkg::START_BYTE);
      serial_bytes.push_back(fcrp_pkg::START_BYTE);
      push_text(",999,0x5");
      serial_bytes.push_back(fcrp_pkg::END_BYTE);
      // Nine hex digits keep only eight; empty flag field; a field past the flag.
      serial_bytes.push_back(fcrp_pkg::START_BYTE);
      push_text(",,123456789,,,7");
      serial_bytes.push_back(fcrp_pkg::END_BYTE);
      target = serial_bytes.size() + RANDOM_BYTES;
      while (serial_bytes.size() < target) begin
         if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 4))
               serial_bytes.push_back(8'($urandom_range(0, 255)));
         push_random_frame();
      end
   endfunction

   // Offers the bytes in order, with random gaps until the final stretch.
   task automatic send_stream();
      int unsigned quiet_from;
      quiet_from = serial_bytes.size() * 85 / 100;
      for (int i = 0; i < serial_bytes.size(); i++) begin
         if (i >= quiet_from) quiet_tail = 1;
         if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         req_if.valid   <= 1'b1;
         req_if.rx_byte <= serial_bytes[i];
         do @(posedge clock); while (!(req_if.valid && req_if.ready));
         @(negedge clock);
      end
      req_if.valid <= 1'b0;
   endtask

   // Response side: random stall bursts and one long hold-off that backs up the block.
   initial begin
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && sb.bytes_taken >= 200) begin
            long_hold_done = 1;
            rsp_if.ready <= 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(negedge clock);
      end
   end

   // Handshake monitor and watchdog.
   always @(posedge clock) begin : monitor
      parsed_record_type got;
      bit                moved;
      if (!reset) begin
         moved = 0;
         if (rsp_if.valid && rsp_if.ready) begin
            got.status        = fcrp_pkg::status_type'(rsp_if.status);
            got.car_id        = rsp_if.car_id;
            got.step_value    = rsp_if.step_value;
            got.position_char = rsp_if.position_char;
            sb.check_record(got);
            moved = 1;
         end
         if (req_if.valid && req_if.ready) begin
            sb.note_byte(req_if.rx_byte);
            moved = 1;
         end
         idle_cycles = moved ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            sb.report_mismatch($sformatf("timeout with %0d records pending",
                                         sb.records_due.size()));
            $display("tb failed");
            $finish;
         end
      end
   end

   initial begin
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      build_stimulus();
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      send_stream();
      while (sb.records_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule
